@@ rtl/hme_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hme_pkg: shared types and codes for the max-heap extract block
// Holds the value type, the status codes, the operation codes and the result
// type of the child selection logic.
// ----------------------------------------------------------------------------
package hme_pkg;

    localparam int unsigned HEAP_DEPTH_DEF = 256;
    localparam int unsigned VAL_W          = 32;
    localparam int unsigned ST_W           = 2;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic [ST_W-1:0]         t_status;

    // Outcome of one sift-down level: whether the hole moves down, and to
    // which child.
    typedef struct packed {
        logic move;
        logic take_right;
    } t_pick;

endpackage

@@ rtl/max_heap_extract.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_heap_extract: binary max-heap with load and extract-max
// A command block around a heap held in a dual-read synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
// A command is transferred at a rising edge where start is high and busy is
// low. i_op selects a load (append i_value at the heap end, no reordering)
// or an extract (return the root). Exactly one result follows each command:
// o_done is high for one cycle with o_max_value, o_status and o_count. The
// receiver cannot stall, so the result must be taken in that cycle.
// A load, a refused load (status full) or an extract on an empty heap is
// answered straight from the idle state. An extract first reads the root
// and the last element; if that leaves the heap empty it returns the root
// without a sift-down, else it runs the sift-down loop, where each level
// has a state for the two-port child read and a state for the compare and
// the single write-back.
// busy is high while an extract is in flight; the next command may be
// transferred in the same cycle as the strobe.
// Reset (synchronous, active low) empties the heap; the memory itself is not
// cleared, since only entries below the element count are ever used.
// ----------------------------------------------------------------------------
module max_heap_extract #(
    parameter int unsigned HEAP_DEPTH = hme_pkg::HEAP_DEPTH_DEF,
    parameter int unsigned CNT_W      = $clog2(HEAP_DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             i_op,
    input  hme_pkg::t_val    i_value,
    output logic             o_done,
    output hme_pkg::t_val    o_max_value,
    output hme_pkg::t_status o_status,
    output logic [CNT_W-1:0] o_count
);
    import hme_pkg::*;

    localparam int unsigned AW = $clog2(HEAP_DEPTH);
    // Child indexes reach 2*HEAP_DEPTH, so they get two more bits.
    localparam int unsigned LW = AW + 2;

    // Controller states: the root read, then alternating child read and
    // compare/write cycles per heap level.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ROOT = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_CMP  = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_done,  n_done;
    t_val             r_max,   n_max;
    t_status          r_status, n_status;
    logic [AW-1:0]    r_idx,   n_idx;
    t_val             r_cur,   n_cur;

    logic          we;
    logic [AW-1:0] waddr;
    t_val          wdata;
    logic [AW-1:0] raddr_a;
    logic [AW-1:0] raddr_b;
    t_val          rdata_a;
    t_val          rdata_b;

    logic [LW-1:0]    left_idx;
    logic [LW-1:0]    right_idx;
    logic [LW-1:0]    count_ext;
    logic [CNT_W-1:0] count_dec;
    logic             heap_full;
    t_pick            pick;

    // The sifted element is kept in r_cur while a hole travels down the
    // tree: each level writes the winning child into the hole, and the last
    // level writes r_cur. This matches a chain of swaps with one write per
    // level. The child reads of a level never touch the entry written at the
    // level before (children always lie deeper), so no forwarding is needed.
    assign left_idx  = {1'b0, r_idx, 1'b1};
    assign right_idx = left_idx + LW'(1);
    assign count_ext = LW'(r_count);
    assign count_dec = r_count - CNT_W'(1);
    assign heap_full = (r_count == CNT_W'(HEAP_DEPTH));

    hme_ram #(
        .DEPTH (HEAP_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    hme_pick u_pick (
        .i_cur      (r_cur),
        .i_left     (rdata_a),
        .i_right    (rdata_b),
        .i_left_ok  (left_idx < count_ext),
        .i_right_ok (right_idx < count_ext),
        .o_pick     (pick)
    );

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_done   = 1'b0;
        n_max    = r_max;
        n_status = r_status;
        n_idx    = r_idx;
        n_cur    = r_cur;
        we       = 1'b0;
        waddr    = r_idx;
        wdata    = r_cur;
        raddr_a  = left_idx[AW-1:0];
        raddr_b  = right_idx[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_op == OP_LOAD) begin
                        n_max  = '0;
                        n_done = 1'b1;
                        if (heap_full) begin
                            n_status = ST_FULL;
                        end else begin
                            we       = 1'b1;
                            waddr    = r_count[AW-1:0];
                            wdata    = i_value;
                            n_count  = r_count + CNT_W'(1);
                            n_status = ST_OK;
                        end
                    end else if (r_count == '0) begin
                        n_max    = '0;
                        n_status = ST_UNDERFLOW;
                        n_done   = 1'b1;
                    end else begin
                        // Fetch the root and the last element together.
                        raddr_a = '0;
                        raddr_b = count_dec[AW-1:0];
                        n_count = count_dec;
                        n_state = S_ROOT;
                    end
                end
            end
            S_ROOT: begin
                n_max    = rdata_a;
                n_cur    = rdata_b;
                n_idx    = '0;
                n_status = ST_OK;
                if (r_count == '0) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                // Child addresses of r_idx are on the read ports by default.
                n_state = S_CMP;
            end
            S_CMP: begin
                we = 1'b1;
                if (pick.move) begin
                    wdata   = pick.take_right ? rdata_b : rdata_a;
                    n_idx   = pick.take_right ? right_idx[AW-1:0] : left_idx[AW-1:0];
                    n_state = S_RD;
                end else begin
                    wdata   = r_cur;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_max    <= n_max;
        r_status <= n_status;
        r_idx    <= n_idx;
        r_cur    <= n_cur;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_max_value = r_max;
    assign o_status    = r_status;
    assign o_count     = r_count;

endmodule

@@ rtl/hme_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hme_ram: heap storage
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module hme_ram #(
    parameter int unsigned DEPTH = hme_pkg::HEAP_DEPTH_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  hme_pkg::t_val i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output hme_pkg::t_val o_rdata_a,
    output hme_pkg::t_val o_rdata_b
);
    import hme_pkg::*;

    t_val mem [DEPTH];
    t_val r_rdata_a;
    t_val r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata_a <= mem[i_raddr_a];
        r_rdata_b <= mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

@@ rtl/hme_pick.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hme_pick: child selection for one sift-down level
// Chooses the larger of the two children when it is strictly larger than the
// element being sifted; on a tie between the children the left one wins.
// ----------------------------------------------------------------------------
module hme_pick (
    input  hme_pkg::t_val  i_cur,
    input  hme_pkg::t_val  i_left,
    input  hme_pkg::t_val  i_right,
    input  logic           i_left_ok,
    input  logic           i_right_ok,
    output hme_pkg::t_pick o_pick
);
    import hme_pkg::*;

    logic left_win;
    logic right_win;
    t_val best_val;

    always_comb begin
        left_win          = i_left_ok && (i_left > i_cur);
        best_val          = left_win ? i_left : i_cur;
        right_win         = i_right_ok && (i_right > best_val);
        o_pick.move       = left_win || right_win;
        o_pick.take_right = right_win;
    end

endmodule
